// File: design/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

    // Width of heap pointer arithmetic; holds offsets past the heap end.
    localparam int PTR_W  = 19;
    localparam int SIZE_W = 16;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_PURGE = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef struct packed {
        logic             valid;
        logic [PTR_W-1:0] ptr;
    } link_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              free;
    } sf_t;

endpackage
`default_nettype wire

// File: design/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: design/first_fit_heap_allocator_unit.sv
// Top level of the first-fit heap allocator: control sequencer and header RAMs.
// Sequence: alloc visits free-list blocks one by one, then writes the header
// updates on a fit; free reads, marks and links the block; purge visits each
// header and merges free runs; each walk step issues one read of the header
// RAMs and then uses the data.
// Throughput: one operation at a time; a new beat is taken once the sequencer
// is idle, even while the previous result beat still waits on the master side.
// Reset: synchronous, active low; after reset the init state writes header 0 as
// one free block spanning the heap, and the list head and tail point to it.
`default_nettype none
module first_fit_heap_allocator_unit #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: [15:0] request_bytes, [28:16] block_offset, [31:29] zero
    input  wire logic [31:0] s_tdata,
    // s_tuser: [1:0] opcode
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: [12:0] payload_offset, [15:13] zero
    output logic [15:0]      m_tdata,
    // m_tuser: [0] granted
    output logic [0:0]       m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready
);

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int PW = ffha_pkg::PTR_W;
    localparam int SW = ffha_pkg::SIZE_W;
    localparam logic [PW-1:0] ANCHOR   = PW'(HEAP_BYTES);
    localparam logic [PW-1:0] SCAN_END = PW'(HEAP_BYTES - 1);
    localparam logic [PW-1:0] HDR_P    = PW'(HEADER_BYTES);
    localparam logic [SW-1:0] HDR_S    = SW'(HEADER_BYTES);
    localparam logic [SW-1:0] INIT_SZ  = SW'(HEAP_BYTES - HEADER_BYTES);

    typedef enum logic [16:0] {
        ST_INIT   = 17'b00000000000000001,
        ST_IDLE   = 17'b00000000000000010,
        ST_A_WALK = 17'b00000000000000100,
        ST_A_CHK  = 17'b00000000000001000,
        ST_A_U1   = 17'b00000000000010000,
        ST_A_U2   = 17'b00000000000100000,
        ST_A_U3   = 17'b00000000001000000,
        ST_F_RD   = 17'b00000000010000000,
        ST_F_WR   = 17'b00000000100000000,
        ST_F_LNK  = 17'b00000001000000000,
        ST_P_TOP  = 17'b00000010000000000,
        ST_P_HDR  = 17'b00000100000000000,
        ST_P_IN   = 17'b00001000000000000,
        ST_P_NXT  = 17'b00010000000000000,
        ST_P_WR   = 17'b00100000000000000,
        ST_P_LNK  = 17'b01000000000000000,
        ST_DONE   = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;

    // List anchor and tail.
    logic          head_valid_reg, head_valid_next;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;

    // Walk registers: cur doubles as the purge scan pointer, prev as its list tail.
    logic [PW-1:0] cur_reg, cur_next;
    logic [PW-1:0] prev_reg, prev_next;
    logic          cur_valid_reg, cur_valid_next;
    logic [PW-1:0] steps_reg, steps_next;
    logic [16:0]   req_reg, req_next;
    ffha_pkg::sf_t   psf_reg, psf_next;
    ffha_pkg::link_t plink_reg, plink_next;
    logic [PW-1:0] nx_reg, nx_next;
    logic [SW-1:0] sz_reg, sz_next;
    logic [SW-1:0] qsize_reg, qsize_next;
    logic          more_reg, more_next;

    // Result.
    logic [12:0] pay_reg, pay_next;
    logic        ok_reg, ok_next;
    logic        m_valid_reg, m_valid_next;
    logic [12:0] m_pay_reg, m_pay_next;
    logic        m_ok_reg, m_ok_next;

    // Header RAM ports.
    logic            ln_we, sf_we;
    logic [AW-1:0]   ln_waddr, sf_waddr, ln_raddr, sf_raddr;
    ffha_pkg::link_t ln_wdata, ln_rdata;
    ffha_pkg::sf_t   sf_wdata, sf_rdata;

    // Link write request, decoded onto the anchor, the RAM or dropped.
    logic            lw_en;
    logic [PW-1:0]   lw_addr;
    ffha_pkg::link_t lw_data;
    logic            sw_en;
    logic [PW-1:0]   sw_addr;
    ffha_pkg::sf_t   sw_data;

    logic [SW-1:0] req16, rem;
    logic          split;
    logic [PW-1:0] n_ptr, boff_p, hdr_end;
    logic [15:0]   req_in;
    logic          n_has;

    assign req16   = req_reg[SW-1:0];
    assign rem     = psf_reg.size - req16 - HDR_S;
    assign split   = (psf_reg.size - req16) > HDR_S;
    assign n_ptr   = cur_reg + PW'(req16) + HDR_P;
    assign n_has   = (n_ptr <= ANCHOR) ? plink_reg.valid : 1'b0;
    assign boff_p  = PW'(s_tdata[28:16]);
    assign req_in  = s_tdata[15:0];
    assign hdr_end = cur_reg + PW'(sf_rdata.size) + HDR_P;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_pay_reg};
    assign m_tuser  = m_ok_reg;

    always_comb begin
        state_next      = state_reg;
        head_valid_next = head_valid_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        cur_valid_next  = cur_valid_reg;
        steps_next      = steps_reg;
        req_next        = req_reg;
        psf_next        = psf_reg;
        plink_next      = plink_reg;
        nx_next         = nx_reg;
        sz_next         = sz_reg;
        qsize_next      = qsize_reg;
        more_next       = more_reg;
        pay_next        = pay_reg;
        ok_next         = ok_reg;
        m_valid_next    = m_valid_reg;
        m_pay_next      = m_pay_reg;
        m_ok_next       = m_ok_reg;
        lw_en           = 1'b0;
        lw_addr         = cur_reg;
        lw_data         = '0;
        sw_en           = 1'b0;
        sw_addr         = cur_reg;
        sw_data         = '0;
        ln_raddr        = cur_reg[AW-1:0];
        sf_raddr        = cur_reg[AW-1:0];

        // Drop the result beat once taken.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT: begin
                sw_en      = 1'b1;
                sw_addr    = '0;
                sw_data    = '{size: INIT_SZ, free: 1'b1};
                lw_en      = 1'b1;
                lw_addr    = '0;
                lw_data    = '0;
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    pay_next = '0;
                    ok_next  = 1'b1;
                    case (ffha_pkg::opcode_t'(s_tuser))
                        ffha_pkg::OP_ALLOC: begin
                            if (req_in[1:0] != 2'b00) begin
                                req_next = {1'b0, req_in[15:2], 2'b00} + 17'd4;
                            end else begin
                                req_next = {1'b0, req_in};
                            end
                            prev_next      = ANCHOR;
                            cur_next       = head_reg;
                            cur_valid_next = head_valid_reg;
                            steps_next     = '0;
                            state_next     = ST_A_WALK;
                        end
                        ffha_pkg::OP_FREE: begin
                            if (boff_p == '0) begin
                                state_next = ST_DONE;
                            end else if (boff_p < HDR_P || boff_p - HDR_P >= ANCHOR) begin
                                ok_next    = 1'b0;
                                state_next = ST_DONE;
                            end else begin
                                cur_next   = boff_p - HDR_P;
                                state_next = ST_F_RD;
                            end
                        end
                        ffha_pkg::OP_PURGE: begin
                            head_valid_next = 1'b0;
                            head_next       = '0;
                            prev_next       = ANCHOR;
                            cur_next        = '0;
                            state_next      = ST_P_TOP;
                        end
                        default: begin
                            ok_next    = 1'b0;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            // Allocate: walk the free list, one header read per step.
            ST_A_WALK: begin
                if (cur_valid_reg && cur_reg < ANCHOR && steps_reg < ANCHOR) begin
                    state_next = ST_A_CHK;
                end else begin
                    ok_next    = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_A_CHK: begin
                if ({1'b0, sf_rdata.size} >= req_reg) begin
                    psf_next   = sf_rdata;
                    plink_next = ln_rdata;
                    state_next = ST_A_U1;
                end else begin
                    prev_next      = cur_reg;
                    cur_valid_next = ln_rdata.valid;
                    cur_next       = ln_rdata.ptr;
                    steps_next     = steps_reg + PW'(1);
                    state_next     = ST_A_WALK;
                end
            end
            ST_A_U1: begin
                lw_en   = 1'b1;
                lw_addr = prev_reg;
                sw_en   = 1'b1;
                if (split) begin
                    lw_data = '{valid: 1'b1, ptr: n_ptr};
                    sw_addr = n_ptr;
                    sw_data = '{size: rem, free: 1'b1};
                end else begin
                    lw_data = plink_reg;
                    sw_data = '{size: psf_reg.size, free: 1'b0};
                end
                state_next = ST_A_U2;
            end
            ST_A_U2: begin
                lw_en = 1'b1;
                sw_en = 1'b1;
                if (split) begin
                    lw_addr = n_ptr;
                    lw_data = plink_reg;
                    sw_data = '{size: req16, free: 1'b0};
                end else begin
                    sw_data = '{size: psf_reg.size, free: 1'b0};
                end
                state_next = ST_A_U3;
            end
            ST_A_U3: begin
                lw_en = 1'b1;
                if (split) begin
                    if (!n_has) begin
                        tail_next = n_ptr;
                    end
                end else if (!plink_reg.valid) begin
                    tail_next = prev_reg;
                end
                pay_next   = 13'(cur_reg + HDR_P);
                state_next = ST_DONE;
            end
            // Free: read size, mark free, append at tail.
            ST_F_RD: begin
                state_next = ST_F_WR;
            end
            ST_F_WR: begin
                sw_en      = 1'b1;
                sw_data    = '{size: sf_rdata.size, free: 1'b1};
                lw_en      = 1'b1;
                state_next = ST_F_LNK;
            end
            ST_F_LNK: begin
                lw_en      = 1'b1;
                lw_addr    = tail_reg;
                lw_data    = '{valid: 1'b1, ptr: cur_reg};
                tail_next  = cur_reg;
                state_next = ST_DONE;
            end
            // Purge: scan headers in address order, merge free runs.
            ST_P_TOP: begin
                if (cur_reg >= SCAN_END) begin
                    tail_next  = prev_reg;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_P_HDR;
                end
            end
            ST_P_HDR: begin
                if (!sf_rdata.free) begin
                    cur_next   = hdr_end;
                    state_next = ST_P_TOP;
                end else begin
                    nx_next    = hdr_end;
                    sz_next    = sf_rdata.size;
                    state_next = ST_P_IN;
                end
            end
            ST_P_IN: begin
                sf_raddr = nx_reg[AW-1:0];
                if (nx_reg >= SCAN_END) begin
                    more_next  = 1'b0;
                    state_next = ST_P_WR;
                end else begin
                    state_next = ST_P_NXT;
                end
            end
            ST_P_NXT: begin
                if (!sf_rdata.free) begin
                    more_next  = 1'b1;
                    qsize_next = sf_rdata.size;
                    state_next = ST_P_WR;
                end else begin
                    sz_next    = sz_reg + sf_rdata.size + HDR_S;
                    nx_next    = nx_reg + PW'(sf_rdata.size) + HDR_P;
                    state_next = ST_P_IN;
                end
            end
            ST_P_WR: begin
                sw_en      = 1'b1;
                sw_data    = '{size: sz_reg, free: 1'b1};
                lw_en      = 1'b1;
                state_next = ST_P_LNK;
            end
            ST_P_LNK: begin
                lw_en     = 1'b1;
                lw_addr   = prev_reg;
                lw_data   = '{valid: 1'b1, ptr: cur_reg};
                prev_next = cur_reg;
                if (more_reg) begin
                    cur_next   = nx_reg + PW'(qsize_reg) + HDR_P;
                    state_next = ST_P_TOP;
                end else begin
                    tail_next  = cur_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_pay_next   = pay_reg;
                    m_ok_next    = ok_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Link writes land on the list anchor, in the heap, or nowhere.
        if (lw_en && lw_addr == ANCHOR) begin
            head_valid_next = lw_data.valid;
            head_next       = lw_data.ptr;
        end
    end

    assign ln_we    = lw_en && (lw_addr < ANCHOR);
    assign ln_waddr = lw_addr[AW-1:0];
    assign ln_wdata = lw_data;
    assign sf_we    = sw_en && (sw_addr < ANCHOR);
    assign sf_waddr = sw_addr[AW-1:0];
    assign sf_wdata = sw_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            head_valid_reg <= 1'b1;
            head_reg       <= '0;
            tail_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_valid_reg <= head_valid_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        cur_valid_reg <= cur_valid_next;
        steps_reg     <= steps_next;
        req_reg       <= req_next;
        psf_reg       <= psf_next;
        plink_reg     <= plink_next;
        nx_reg        <= nx_next;
        sz_reg        <= sz_next;
        qsize_reg     <= qsize_next;
        more_reg      <= more_next;
        pay_reg       <= pay_next;
        ok_reg        <= ok_next;
        m_pay_reg     <= m_pay_next;
        m_ok_reg      <= m_ok_next;
    end

    // Link half of each header: next-free valid bit and pointer.
    ffha_ram #(
        .WIDTH ($bits(ffha_pkg::link_t)),
        .DEPTH (HEAP_BYTES)
    ) u_link_ram (
        .clk   (aclk),
        .we    (ln_we),
        .waddr (ln_waddr),
        .wdata (ln_wdata),
        .raddr (ln_raddr),
        .rdata (ln_rdata)
    );

    // Size and free mark of each header.
    ffha_ram #(
        .WIDTH ($bits(ffha_pkg::sf_t)),
        .DEPTH (HEAP_BYTES)
    ) u_sf_ram (
        .clk   (aclk),
        .we    (sf_we),
        .waddr (sf_waddr),
        .wdata (sf_wdata),
        .raddr (sf_raddr),
        .rdata (sf_rdata)
    );

endmodule
`default_nettype wire

// File: tb/first_fit_heap_allocator_unit_tb.sv
// Self-checking testbench for the first-fit heap allocator unit.
`default_nettype none
module first_fit_heap_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HEAP   = 4096;
    localparam int unsigned HDR    = 8;
    // Pseudo header that stands for the list head pointer.
    localparam int unsigned ANCHOR = HEAP;
    localparam int unsigned SCAN_END = HEAP - 1;
    localparam int DIRECTED = 25;
    localparam int RANDOM_ITEMS = 750;

    // How the free target of a queued beat is chosen when it is driven.
    typedef enum logic [1:0] {
        TGT_FIXED = 2'd0,
        TGT_LIVE  = 2'd1,
        TGT_LAST  = 2'd2
    } target_t;

    typedef struct {
        ffha_pkg::opcode_t op;
        logic [15:0]       req;
        logic [12:0]       boff;
        target_t           tgt;
    } cmd_t;

    typedef struct {
        logic [12:0] pay;
        logic        ok;
    } grant_t;

    logic        aclk;
    logic        aresetn;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready;

    first_fit_heap_allocator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // Shadow heap: one header per byte offset, plus list head and tail.
    logic [15:0] hsize [HEAP];
    bit          hfree [HEAP];
    bit          hlinked [HEAP];
    int unsigned hlink [HEAP];
    bit          head_valid;
    int unsigned head_ptr;
    int unsigned tail_ptr;

    cmd_t        cmd_q [$];
    grant_t      grant_q [$];
    int unsigned live_q [$];    // payload offsets currently handed out
    int unsigned last_pay;
    int          sent;
    int          errors;
    bit          s_took;

    function automatic void set_link(int unsigned n, bit v, int unsigned l);
        if (n == ANCHOR) begin
            head_valid = v;
            head_ptr = l;
        end else if (n < HEAP) begin
            hlinked[n] = v;
            hlink[n] = l;
        end
    endfunction

    function automatic void heap_init();
        for (int i = 0; i < HEAP; i++) begin
            hsize[i] = '0;
            hfree[i] = 0;
            hlinked[i] = 0;
            hlink[i] = 0;
        end
        hsize[0] = 16'(HEAP - HDR);
        hfree[0] = 1;
        head_valid = 1;
        head_ptr = 0;
        tail_ptr = 0;
    endfunction

    function automatic void first_fit(input int unsigned req, output int unsigned pay,
                                      output bit ok);
        int unsigned need, prev, cur, steps, n, psz, plink;
        bit cur_v, found, plinked, n_linked;
        need = req;
        prev = ANCHOR;
        cur = head_ptr;
        cur_v = head_valid;
        steps = 0;
        found = 0;
        pay = 0;
        ok = 0;
        if (need & 3) need = (need & 32'hFFFF_FFFC) + 4;
        // Walk the list; a runaway walk on a cyclic list stops after HEAP steps.
        while (cur_v && cur < HEAP && steps < HEAP) begin
            if (hsize[cur] >= need) begin
                found = 1;
                break;
            end
            prev = cur;
            cur_v = hlinked[cur];
            cur = hlink[cur];
            steps++;
        end
        if (!found) return;
        psz = hsize[cur];
        plinked = hlinked[cur];
        plink = hlink[cur];
        if (psz - need <= HDR) begin
            // Take the whole block out of the list.
            set_link(prev, plinked, plink);
            if (!plinked) tail_ptr = prev;
        end else begin
            // Split: the remainder takes the block's place in the list.
            n = cur + need + HDR;
            set_link(prev, 1, n);
            set_link(n, plinked, plink);
            hsize[n] = 16'(psz - need - HDR);
            hfree[n] = 1;
            hsize[cur] = 16'(need);
            // The anchor pseudo header reports the list head's valid bit.
            if (n == ANCHOR) n_linked = head_valid;
            else if (n < HEAP) n_linked = hlinked[n];
            else n_linked = 0;
            if (!n_linked) tail_ptr = n;
        end
        hlinked[cur] = 0;
        hlink[cur] = 0;
        hfree[cur] = 0;
        ok = 1;
        pay = cur + HDR;
    endfunction

    function automatic void coalesce();
        int unsigned p, prev, nx, sz;
        p = 0;
        prev = ANCHOR;
        head_valid = 0;
        head_ptr = 0;
        while (p < SCAN_END) begin
            if (!hfree[p]) begin
                p += hsize[p] + HDR;
                continue;
            end
            nx = p + hsize[p] + HDR;
            sz = hsize[p];
            while (nx < SCAN_END && hfree[nx]) begin
                sz += hsize[nx] + HDR;
                nx += hsize[nx] + HDR;
            end
            hsize[p] = 16'(sz);
            hlinked[p] = 0;
            hlink[p] = 0;
            set_link(prev, 1, p);
            prev = p;
            if (nx < SCAN_END) p = nx + hsize[nx] + HDR;
            else break;
        end
        tail_ptr = prev;
    endfunction

    // Work out the result of one accepted beat and advance the shadow heap.
    function automatic grant_t heap_op(ffha_pkg::opcode_t op, int unsigned req,
                                       int unsigned boff);
        grant_t g;
        int unsigned pay, h;
        bit ok;
        pay = 0;
        ok = 1;
        case (op)
            ffha_pkg::OP_ALLOC: begin
                first_fit(req, pay, ok);
                if (ok) begin
                    live_q.push_back(pay);
                    last_pay = pay;
                end
            end
            ffha_pkg::OP_FREE: begin
                if (boff != 0) begin
                    if (boff < HDR || boff - HDR >= HEAP) begin
                        ok = 0;
                    end else begin
                        h = boff - HDR;
                        hfree[h] = 1;
                        hlinked[h] = 0;
                        hlink[h] = 0;
                        set_link(tail_ptr, 1, h);
                        tail_ptr = h;
                        foreach (live_q[i]) begin
                            if (live_q[i] == boff) begin
                                live_q.delete(i);
                                break;
                            end
                        end
                    end
                end
            end
            ffha_pkg::OP_PURGE: coalesce();
            default: ok = 0;
        endcase
        g.pay = 13'(pay);
        g.ok = ok;
        return g;
    endfunction

    // Idling phases of the random part: none, sender, receiver, both.
    function automatic int idle_phase();
        if (sent < DIRECTED) return 0;
        return ((sent - DIRECTED) / 150) % 4;
    endfunction

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Driver: present the next beat at the falling edge, hold it until taken.
    always @(negedge aclk) begin
        cmd_t c;
        int ph;
        ph = idle_phase();
        if (aresetn) begin
            if (!s_tvalid || s_took) begin
                if (cmd_q.size() > 0 &&
                    !((ph == 1 && $urandom_range(0, 99) < 80) ||
                      (ph == 3 && $urandom_range(0, 99) < 10))) begin
                    c = cmd_q.pop_front();
                    if (c.tgt == TGT_LIVE)
                        c.boff = (live_q.size() == 0) ? 13'd0 :
                                 13'(live_q[$urandom_range(0, live_q.size() - 1)]);
                    else if (c.tgt == TGT_LAST)
                        c.boff = 13'(last_pay);
                    s_tdata <= {3'b000, c.boff, c.req};
                    s_tuser <= c.op;
                    s_tvalid <= 1'b1;
                    sent++;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !((ph == 2 && $urandom_range(0, 99) < 80) ||
                          (ph == 3 && $urandom_range(0, 99) < 10));
        end
    end

    // Monitor: check result beats, then predict for the input beat just taken.
    always @(posedge aclk) begin
        grant_t want;
        s_took <= s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (grant_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%t: unexpected result beat pay=%0d granted=%0d",
                                 $realtime, m_tdata[12:0], m_tuser[0]);
                end else begin
                    want = grant_q.pop_front();
                    if (m_tdata[12:0] !== want.pay || m_tuser[0] !== want.ok) begin
                        errors++;
                        if (errors <= 10)
                            $display("%t: mismatch pay exp %0d got %0d, granted exp %0d got %0d",
                                     $realtime, want.pay, m_tdata[12:0], want.ok, m_tuser[0]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                grant_q.push_back(heap_op(ffha_pkg::opcode_t'(s_tuser), s_tdata[15:0],
                                          s_tdata[28:16]));
        end
    end

    task automatic queue_cmd(ffha_pkg::opcode_t op, int unsigned req, int unsigned boff,
                             target_t tgt);
        cmd_t c;
        c.op = op;
        c.req = 16'(req);
        c.boff = 13'(boff);
        c.tgt = tgt;
        cmd_q.push_back(c);
    endtask

    initial begin
        int r;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = ffha_pkg::OP_NONE;
        m_tready = 0;
        s_took = 0;
        sent = 0;
        errors = 0;
        last_pay = 0;
        heap_init();

        // Exact fit of the whole heap empties the list; freeing it refills it.
        queue_cmd(ffha_pkg::OP_ALLOC, HEAP - HDR, 0, TGT_FIXED);
        queue_cmd(ffha_pkg::OP_ALLOC, 1, 0, TGT_FIXED);
        queue_cmd(ffha_pkg::OP_FREE, 0, 0, TGT_LAST);
        queue_cmd(ffha_pkg::OP_ALLOC, 0, 0, TGT_FIXED);
        queue_cmd(ffha_pkg::OP_ALLOC, 1, 0, TGT_FIXED);
        queue_cmd(ffha_pkg::OP_ALLOC, 13, 0, TGT_FIXED);
        queue_cmd(ffha_pkg::OP_ALLOC, 65535, 0, TGT_FIXED);
        queue_cmd(ffha_pkg::OP_ALLOC, 65533, 0, TGT_FIXED);
        queue_cmd(ffha_pkg::OP_FREE, 0, 0, TGT_LIVE);
        queue_cmd(ffha_pkg::OP_FREE, 0, 0, TGT_FIXED);
        queue_cmd(ffha_pkg::OP_FREE, 0, 4, TGT_FIXED);
        queue_cmd(ffha_pkg::OP_FREE, 0, 8191, TGT_FIXED);
        queue_cmd(ffha_pkg::OP_FREE, 0, HEAP + HDR, TGT_FIXED);
        queue_cmd(ffha_pkg::OP_NONE, 16'hFFFF, 13'h1FFF, TGT_FIXED);
        queue_cmd(ffha_pkg::OP_PURGE, 0, 0, TGT_FIXED);
        queue_cmd(ffha_pkg::OP_FREE, 0, 0, TGT_LIVE);
        queue_cmd(ffha_pkg::OP_FREE, 0, 0, TGT_LIVE);
        queue_cmd(ffha_pkg::OP_PURGE, 0, 0, TGT_FIXED);
        // Double free makes a self loop; the walk gives up and reports no fit.
        queue_cmd(ffha_pkg::OP_ALLOC, 100, 0, TGT_FIXED);
        queue_cmd(ffha_pkg::OP_FREE, 0, 0, TGT_LAST);
        queue_cmd(ffha_pkg::OP_FREE, 0, 0, TGT_LAST);
        queue_cmd(ffha_pkg::OP_ALLOC, 4000, 0, TGT_FIXED);
        queue_cmd(ffha_pkg::OP_PURGE, 0, 0, TGT_FIXED);

        // Random part: mostly alloc/free of live blocks, some purge and noise.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 48) begin
                r = $urandom_range(0, 99);
                queue_cmd(ffha_pkg::OP_ALLOC, r < 85 ? $urandom_range(0, 160) :
                          r < 97 ? $urandom_range(0, 1024) : $urandom_range(0, 65535),
                          $urandom_range(0, 8191), TGT_FIXED);
            end else if (r < 85) begin
                queue_cmd(ffha_pkg::OP_FREE, $urandom_range(0, 65535), 0, TGT_LIVE);
            end else if (r < 93) begin
                queue_cmd(ffha_pkg::OP_PURGE, $urandom_range(0, 65535),
                          $urandom_range(0, 8191), TGT_FIXED);
            end else if (r < 95) begin
                queue_cmd(ffha_pkg::OP_FREE, $urandom_range(0, 65535), 0, TGT_FIXED);
            end else if (r < 98) begin
                queue_cmd(ffha_pkg::OP_FREE, 0,
                          $urandom_range(0, 1) ? $urandom_range(1, HDR - 1) :
                          $urandom_range(HEAP + HDR, 8191), TGT_FIXED);
            end else begin
                queue_cmd(ffha_pkg::OP_NONE, $urandom_range(0, 65535),
                          $urandom_range(0, 8191), TGT_FIXED);
            end
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Drain: every beat taken, every result seen, then a quiet tail.
        while (cmd_q.size() > 0 || s_tvalid) @(posedge aclk);
        while (grant_q.size() > 0) @(posedge aclk);
        repeat (500) @(posedge aclk);
        if (errors == 0)
            $display("** first_fit_heap_allocator_unit: PASSED **");
        else
            $display("** first_fit_heap_allocator_unit: FAILED **");
        $finish;
    end

    initial begin
        #50ms;
        $display("** first_fit_heap_allocator_unit: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire
